FILE: design/sts_pkg.sv
// Package for the source token scanner: token kinds, scan modes, result type
// and the byte classification and keyword functions.
// No dependencies.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int PosW      = 16;
    localparam int KwChars   = 8;
    localparam int KwIdxW    = 3;
    localparam logic [PosW-1:0] PosMax = 16'hFFFF;

    localparam logic [5:0] KIND_IDENT    = 6'd0;
    localparam logic [5:0] KIND_INTEGER  = 6'd1;
    localparam logic [5:0] KIND_BOOLEAN  = 6'd2;
    localparam logic [5:0] KIND_AND      = 6'd3;
    localparam logic [5:0] KIND_BOOL     = 6'd4;
    localparam logic [5:0] KIND_BREAK    = 6'd5;
    localparam logic [5:0] KIND_CONTINUE = 6'd6;
    localparam logic [5:0] KIND_DO       = 6'd7;
    localparam logic [5:0] KIND_ELSE     = 6'd8;
    localparam logic [5:0] KIND_IF       = 6'd9;
    localparam logic [5:0] KIND_INT      = 6'd10;
    localparam logic [5:0] KIND_NOT      = 6'd11;
    localparam logic [5:0] KIND_OR       = 6'd12;
    localparam logic [5:0] KIND_RETURN   = 6'd13;
    localparam logic [5:0] KIND_THEN     = 6'd14;
    localparam logic [5:0] KIND_WHILE    = 6'd15;
    localparam logic [5:0] KIND_PLUS     = 6'd16;
    localparam logic [5:0] KIND_MINUS    = 6'd17;
    localparam logic [5:0] KIND_STAR     = 6'd18;
    localparam logic [5:0] KIND_SLASH    = 6'd19;
    localparam logic [5:0] KIND_LPAREN   = 6'd20;
    localparam logic [5:0] KIND_RPAREN   = 6'd21;
    localparam logic [5:0] KIND_LBRACK   = 6'd22;
    localparam logic [5:0] KIND_RBRACK   = 6'd23;
    localparam logic [5:0] KIND_LBRACE   = 6'd24;
    localparam logic [5:0] KIND_RBRACE   = 6'd25;
    localparam logic [5:0] KIND_COMMA    = 6'd26;
    localparam logic [5:0] KIND_SEMI     = 6'd27;
    localparam logic [5:0] KIND_COLON    = 6'd28;
    localparam logic [5:0] KIND_ASSIGN   = 6'd29;
    localparam logic [5:0] KIND_EQUAL    = 6'd30;
    localparam logic [5:0] KIND_EQEQ     = 6'd31;
    localparam logic [5:0] KIND_ARROW    = 6'd32;
    localparam logic [5:0] KIND_LESS     = 6'd33;
    localparam logic [5:0] KIND_LESSEQ   = 6'd34;
    localparam logic [5:0] KIND_GREATER  = 6'd35;
    localparam logic [5:0] KIND_GREATEQ  = 6'd36;
    localparam logic [5:0] KIND_NOTEQ    = 6'd37;
    localparam logic [5:0] KIND_EOF      = 6'd38;
    localparam logic [5:0] KIND_ERROR    = 6'd39;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_NAME,
        MODE_COMMENT,
        MODE_OPERATOR
    } t_mode;

    // One result item.
    typedef struct packed {
        logic [5:0]      kind;
        logic [PosW-1:0] sl;
        logic [PosW-1:0] sc;
        logic [PosW-1:0] el;
        logic [PosW-1:0] ec;
        logic [PosW-1:0] len;
        logic [7:0]      bad;
        logic            last;
    } t_result;

    // Classified byte handed from front to back.
    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        logic       is_num;
        logic       is_letter;
        logic       is_blank;
        logic       is_nl;
        logic       is_hash;
        logic       is_pend;
        logic [5:0] lone;
        logic       lone_ok;
    } t_item;

    typedef logic [KwChars*8-1:0] t_prefix;

    function automatic logic digit_f(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_letter_f(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
    endfunction

    function automatic logic [6:0] lone_f(input logic [7:0] b);
        logic [6:0] r;
        begin
            unique case (b)
                8'h2B: r = {1'b1, KIND_PLUS};
                8'h2D: r = {1'b1, KIND_MINUS};
                8'h2A: r = {1'b1, KIND_STAR};
                8'h2F: r = {1'b1, KIND_SLASH};
                8'h28: r = {1'b1, KIND_LPAREN};
                8'h29: r = {1'b1, KIND_RPAREN};
                8'h5B: r = {1'b1, KIND_LBRACK};
                8'h5D: r = {1'b1, KIND_RBRACK};
                8'h7B: r = {1'b1, KIND_LBRACE};
                8'h7D: r = {1'b1, KIND_RBRACE};
                8'h2C: r = {1'b1, KIND_COMMA};
                8'h3B: r = {1'b1, KIND_SEMI};
                default: r = 7'd0;
            endcase
            return r;
        end
    endfunction

    // Packs a word into the prefix layout: byte i at bits [8i+7:8i].
    function automatic t_prefix word_f(input logic [8*8-1:0] s, input int n);
        t_prefix p;
        begin
            p = '0;
            for (int i = 0; i < 8; i++) begin
                if (i < n) p[i*8 +: 8] = s[(n-1-i)*8 +: 8];
            end
            return p;
        end
    endfunction

    // Keyword lookup over a whole name of at most KwChars bytes.
    function automatic logic [5:0] kw_f(input t_prefix p, input logic [PosW-1:0] len);
        logic [5:0] k;
        begin
            k = KIND_IDENT;
            if (len == 16'd3 && p == word_f("and", 3))      k = KIND_AND;
            if (len == 16'd4 && p == word_f("bool", 4))     k = KIND_BOOL;
            if (len == 16'd5 && p == word_f("break", 5))    k = KIND_BREAK;
            if (len == 16'd8 && p == word_f("continue", 8)) k = KIND_CONTINUE;
            if (len == 16'd2 && p == word_f("do", 2))       k = KIND_DO;
            if (len == 16'd4 && p == word_f("else", 4))     k = KIND_ELSE;
            if (len == 16'd2 && p == word_f("if", 2))       k = KIND_IF;
            if (len == 16'd3 && p == word_f("int", 3))      k = KIND_INT;
            if (len == 16'd3 && p == word_f("not", 3))      k = KIND_NOT;
            if (len == 16'd2 && p == word_f("or", 2))       k = KIND_OR;
            if (len == 16'd6 && p == word_f("return", 6))   k = KIND_RETURN;
            if (len == 16'd4 && p == word_f("then", 4))     k = KIND_THEN;
            if (len == 16'd5 && p == word_f("while", 5))    k = KIND_WHILE;
            if (len == 16'd4 && p == word_f("true", 4))     k = KIND_BOOLEAN;
            if (len == 16'd5 && p == word_f("false", 5))    k = KIND_BOOLEAN;
            return k;
        end
    endfunction

endpackage

FILE: design/sts_front.sv
// Front of the scanner: accepts bytes, classifies them and queues them.
// Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_front import sts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_q_pop
);

    // Two-entry queue.
    t_item      r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_item      w_item;
    logic [6:0] w_lone;
    logic       w_push;

    // Classify the incoming byte.
    always_comb begin
        w_lone           = lone_f(i_text_byte);
        w_item.b         = i_text_byte;
        w_item.eot       = i_end_of_text;
        w_item.is_num    = digit_f(i_text_byte);
        w_item.is_letter = is_letter_f(i_text_byte);
        w_item.is_nl     = i_text_byte == 8'h0A;
        w_item.is_blank  = i_text_byte == 8'h20 || i_text_byte == 8'h09 || i_text_byte == 8'h0A;
        w_item.is_hash   = i_text_byte == 8'h23;
        w_item.is_pend   = i_text_byte == 8'h3A || i_text_byte == 8'h3D ||
                           i_text_byte == 8'h3C || i_text_byte == 8'h3E ||
                           i_text_byte == 8'h21;
        w_item.lone      = w_lone[5:0];
        w_item.lone_ok   = w_lone[6];
    end

    assign o_stall   = r_cnt == 2'd2;
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_item  = r_mem[r_rp];

    // Queue pointers.
    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ i_q_pop;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_item;
    end

endmodule

FILE: design/sts_back.sv
// Back of the scanner: the token state machine and a four-entry result buffer.
// Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_back import sts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_item   i_q_item,
    output logic    o_q_pop,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_stall
);

    t_mode           r_mode, n_mode;
    logic [PosW-1:0] r_line, n_line, r_col, n_col;
    logic [PosW-1:0] r_sl, n_sl, r_sc, n_sc, r_len, n_len;
    t_prefix         r_pre, n_pre;
    logic [7:0]      r_pend, n_pend;

    t_result    r_buf [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    t_result    w_r0, w_r1;
    logic       w_v0, w_v1, w_take, w_pop_out;

    logic            w_done;
    logic [PosW:0]   w_endc;
    logic [PosW-1:0] w_ecs;
    logic [PosW-1:0] w_col_inc, w_line_inc;
    logic [5:0]      w_pair;
    t_result         w_flush_res, w_idle_res;
    logic            w_flush_v, w_idle_v;
    t_item           it;

    // Room for two results is needed before a byte is taken.
    assign w_take    = i_q_valid && (r_cnt <= 3'd2);
    assign o_q_pop   = w_take;
    assign o_valid   = r_cnt != 3'd0;
    assign o_res     = r_buf[r_rp];
    assign w_pop_out = o_valid && !i_stall;
    assign it        = i_q_item;

    assign w_col_inc  = (r_col == PosMax) ? PosMax : r_col + 16'd1;
    assign w_line_inc = (r_line == PosMax) ? PosMax : r_line + 16'd1;

    // End column of a run, saturated.
    always_comb begin
        w_endc = {1'b0, r_sc} + {1'b0, r_len} - 17'd1;
        if (r_len == '0) w_endc = {1'b0, r_sc};
        w_ecs = w_endc[PosW] ? PosMax : w_endc[PosW-1:0];
    end

    // Two-character operator lookup.
    always_comb begin
        w_pair = 6'd0;
        if (it.b == 8'h3D) begin
            unique case (r_pend)
                8'h3A:   w_pair = KIND_ASSIGN;
                8'h3D:   w_pair = KIND_EQEQ;
                8'h3C:   w_pair = KIND_LESSEQ;
                8'h3E:   w_pair = KIND_GREATEQ;
                8'h21:   w_pair = KIND_NOTEQ;
                default: w_pair = 6'd0;
            endcase
        end else if (it.b == 8'h3E && r_pend == 8'h3D) begin
            w_pair = KIND_ARROW;
        end
    end

    // Result that closes the pending token.
    always_comb begin
        w_flush_res = '0;
        w_flush_v   = 1'b0;
        unique case (r_mode)
            MODE_NUMBER, MODE_NAME: begin
                w_flush_v        = 1'b1;
                w_flush_res.kind = (r_mode == MODE_NUMBER) ? KIND_INTEGER :
                                   (r_len > 16'(KwChars)) ? KIND_IDENT : kw_f(r_pre, r_len);
                w_flush_res.sl   = r_sl;
                w_flush_res.sc   = r_sc;
                w_flush_res.el   = r_sl;
                w_flush_res.ec   = w_ecs;
                w_flush_res.len  = r_len;
            end
            MODE_OPERATOR: begin
                w_flush_v = 1'b1;
                w_flush_res.sl  = r_sl;
                w_flush_res.sc  = r_sc;
                w_flush_res.el  = r_sl;
                w_flush_res.ec  = r_sc;
                w_flush_res.len = 16'd1;
                unique case (r_pend)
                    8'h3A:   w_flush_res.kind = KIND_COLON;
                    8'h3D:   w_flush_res.kind = KIND_EQUAL;
                    8'h3C:   w_flush_res.kind = KIND_LESS;
                    8'h3E:   w_flush_res.kind = KIND_GREATER;
                    default: begin
                        w_flush_res.kind = KIND_ERROR;
                        w_flush_res.bad  = r_pend;
                    end
                endcase
            end
            default: w_flush_v = 1'b0;
        endcase
    end

    // Single-byte result from idle.
    always_comb begin
        w_idle_res     = '0;
        w_idle_res.sl  = r_line;
        w_idle_res.sc  = r_col;
        w_idle_res.el  = r_line;
        w_idle_res.ec  = r_col;
        w_idle_res.len = 16'd1;
        w_idle_v       = 1'b0;
        if (it.is_blank || it.is_hash || it.is_num || it.is_letter || it.is_pend) begin
            w_idle_v = 1'b0;
        end else if (it.lone_ok) begin
            w_idle_v        = 1'b1;
            w_idle_res.kind = it.lone;
        end else begin
            w_idle_v        = 1'b1;
            w_idle_res.kind = KIND_ERROR;
            w_idle_res.bad  = it.b;
        end
    end

    // Next state and results of one byte.
    always_comb begin
        n_mode = r_mode; n_line = r_line; n_col = r_col;
        n_sl = r_sl; n_sc = r_sc; n_len = r_len; n_pre = r_pre; n_pend = r_pend;
        w_r0 = '0; w_r1 = '0; w_v0 = 1'b0; w_v1 = 1'b0;
        w_done = 1'b0;
        if (it.eot) begin
            w_v0 = w_flush_v;
            w_r0 = w_flush_res;
            w_v1 = 1'b1;
            w_r1.kind = KIND_EOF;
            w_r1.sl = r_line; w_r1.sc = r_col; w_r1.el = r_line; w_r1.ec = r_col;
            w_r1.len = 16'd5;
            n_mode = MODE_IDLE; n_line = 16'd1; n_col = 16'd1;
            n_sl = 16'd1; n_sc = 16'd1; n_len = '0; n_pre = '0; n_pend = '0;
        end else begin
            unique case (r_mode)
                MODE_NUMBER: w_done = it.is_num;
                MODE_NAME:   w_done = it.is_num || it.is_letter;
                MODE_COMMENT: w_done = !it.is_nl;
                MODE_OPERATOR: w_done = w_pair != 6'd0;
                default:     w_done = 1'b0;
            endcase
            if (w_done) begin
                if (r_mode == MODE_NAME && r_len < 16'(KwChars))
                    n_pre[r_len[KwIdxW-1:0]*8 +: 8] = it.b;
                if ((r_mode == MODE_NAME || r_mode == MODE_NUMBER) && r_len != PosMax)
                    n_len = r_len + 16'd1;
                if (r_mode == MODE_OPERATOR) begin
                    w_v1 = 1'b1;
                    w_r1.kind = w_pair;
                    w_r1.sl = r_sl; w_r1.sc = r_sc; w_r1.el = r_line; w_r1.ec = r_col;
                    w_r1.len = 16'd2;
                    n_pend = '0;
                    n_mode = MODE_IDLE;
                end
                n_col = w_col_inc;
            end else begin
                w_v0   = w_flush_v;
                w_r0   = w_flush_res;
                n_mode = MODE_IDLE;
                n_pend = (r_mode == MODE_OPERATOR) ? 8'd0 : r_pend;
                w_v1   = w_idle_v;
                w_r1   = w_idle_res;
                if (it.is_hash) begin
                    n_mode = MODE_COMMENT;
                end else if (it.is_num || it.is_letter || (it.is_pend && !it.lone_ok)) begin
                    n_sl = r_line; n_sc = r_col; n_len = 16'd1;
                    if (it.is_num) n_mode = MODE_NUMBER;
                    else if (it.is_letter) begin
                        n_mode = MODE_NAME;
                        n_pre  = '0;
                        n_pre[7:0] = it.b;
                    end else begin
                        n_mode = MODE_OPERATOR;
                        n_pend = it.b;
                    end
                end
                if (it.is_nl) begin
                    n_line = w_line_inc;
                    n_col  = 16'd1;
                end else begin
                    n_col = w_col_inc;
                end
            end
        end
        // Mark the final result of this byte.
        if (w_v1) w_r1.last = 1'b1;
        else      w_r0.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_line <= 16'd1; r_col <= 16'd1;
            r_sl <= 16'd1; r_sc <= 16'd1; r_len <= '0;
            r_pre <= '0; r_pend <= '0;
        end else if (w_take) begin
            r_mode <= n_mode;
            r_line <= n_line; r_col <= n_col;
            r_sl <= n_sl; r_sc <= n_sc; r_len <= n_len;
            r_pre <= n_pre; r_pend <= n_pend;
        end
    end

    // Result buffer: up to two writes, one read per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + {1'b0, w_take && w_v0} + {1'b0, w_take && w_v1};
            r_rp  <= r_rp + {1'b0, w_pop_out};
            r_cnt <= r_cnt + {2'b0, w_take && w_v0} + {2'b0, w_take && w_v1}
                     - {2'b0, w_pop_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_v0) r_buf[r_wp] <= w_r0;
        if (w_take && w_v1) r_buf[w_v0 ? r_wp + 2'd1 : r_wp] <= w_r1;
    end

endmodule

FILE: design/source_token_scanner.sv
// Top level of the source token scanner: front classifier and back tokenizer.
// Depends on sts_pkg, sts_front and sts_back.
//
//   Channel | Direction | Fields
//   input   | in        | i_text_byte, i_end_of_text (i_valid / o_stall)
//   result  | out       | o_token_kind .. o_last_of_run (o_valid / i_stall)
//
// One byte per cycle is sustained while the four-entry result buffer has room; a
// byte is registered in the front queue and its results in the result buffer before
// they can be taken. A two-result byte holds the back only as that buffer fills.
// Reset is synchronous and returns line and column to 1 with both queues empty.
// A stalled result keeps its fields; the front keeps taking bytes until its
// two-entry queue is full.
`timescale 1ns / 1ps

module source_token_scanner import sts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [15:0] o_end_line,
    output logic [15:0] o_end_column,
    output logic [15:0] o_token_length,
    output logic [7:0]  o_bad_byte,
    output logic        o_last_of_run
);

    logic    w_q_valid, w_q_pop;
    t_item   w_q_item;
    t_result w_res;

    // Byte classification and queue.
    sts_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_text_byte, .i_end_of_text,
        .o_q_valid(w_q_valid), .o_q_item(w_q_item), .i_q_pop(w_q_pop)
    );

    // Token state machine and result buffer.
    sts_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_q_valid), .i_q_item(w_q_item),
        .o_q_pop(w_q_pop), .o_valid, .o_res(w_res), .i_stall
    );

    assign o_token_kind   = w_res.kind;
    assign o_start_line   = w_res.sl;
    assign o_start_column = w_res.sc;
    assign o_end_line     = w_res.el;
    assign o_end_column   = w_res.ec;
    assign o_token_length = w_res.len;
    assign o_bad_byte     = w_res.bad;
    assign o_last_of_run  = w_res.last;

endmodule

FILE: sim/token_checker.sv
// Checker for the source token scanner: watches both channels, predicts the
// tokens of every accepted request and compares them with the block's results.
// Depends on sts_pkg.
`timescale 1ns / 1ps

module token_checker import sts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [5:0]  i_token_kind,
    input  logic [15:0] i_start_line,
    input  logic [15:0] i_start_column,
    input  logic [15:0] i_end_line,
    input  logic [15:0] i_end_column,
    input  logic [15:0] i_token_length,
    input  logic [7:0]  i_bad_byte,
    input  logic        i_last_of_run,
    output int          o_errors,
    output int          o_pending
);

    localparam int NO_KIND = -1;
    localparam int REPORT_MAX = 10;

    string      kw_word [15];
    logic [5:0] kw_kind [15];

    // Scanner state as the block should hold it.
    t_mode       mode;
    logic [15:0] cur_ln, cur_col, tok_ln, tok_col, run_len;
    logic [7:0]  prefix [KwChars];
    logic [7:0]  pend;

    t_result tokens_due [$];
    t_result step_out [$];
    int      errors;

    assign o_errors  = errors;
    assign o_pending = tokens_due.size();

    initial begin
        kw_word = '{"and", "bool", "break", "continue", "do", "else", "if", "int",
                    "not", "or", "return", "then", "while", "true", "false"};
        kw_kind = '{KIND_AND, KIND_BOOL, KIND_BREAK, KIND_CONTINUE, KIND_DO, KIND_ELSE,
                    KIND_IF, KIND_INT, KIND_NOT, KIND_OR, KIND_RETURN, KIND_THEN,
                    KIND_WHILE, KIND_BOOLEAN, KIND_BOOLEAN};
        errors = 0;
    end

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == PosMax) ? v : v + 16'd1;
    endfunction

    function automatic bit is_dig(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_let(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic int single_op(input logic [7:0] b);
        case (b)
            "+": return KIND_PLUS;
            "-": return KIND_MINUS;
            "*": return KIND_STAR;
            "/": return KIND_SLASH;
            "(": return KIND_LPAREN;
            ")": return KIND_RPAREN;
            "[": return KIND_LBRACK;
            "]": return KIND_RBRACK;
            "{": return KIND_LBRACE;
            "}": return KIND_RBRACE;
            ",": return KIND_COMMA;
            ";": return KIND_SEMI;
            default: return NO_KIND;
        endcase
    endfunction

    function automatic int double_op(input logic [7:0] first, input logic [7:0] second);
        if (second == "=") begin
            case (first)
                ":": return KIND_ASSIGN;
                "=": return KIND_EQEQ;
                "<": return KIND_LESSEQ;
                ">": return KIND_GREATEQ;
                "!": return KIND_NOTEQ;
                default: return NO_KIND;
            endcase
        end
        if (second == ">" && first == "=") return KIND_ARROW;
        return NO_KIND;
    endfunction

    task automatic add_token(input logic [5:0] kind, input logic [15:0] sl,
                             input logic [15:0] sc, input logic [15:0] el,
                             input logic [15:0] ec, input logic [15:0] len,
                             input logic [7:0] bad);
        t_result r;
        r = '{kind, sl, sc, el, ec, len, bad, 1'b0};
        step_out.push_back(r);
    endtask

    task automatic clear_state();
        mode    = MODE_IDLE;
        cur_ln  = 16'd1;
        cur_col = 16'd1;
        tok_ln  = 16'd1;
        tok_col = 16'd1;
        run_len = 16'd0;
        pend    = 8'd0;
        foreach (prefix[i]) prefix[i] = 8'd0;
    endtask

    task automatic advance(input logic [7:0] b);
        if (b == "\n") begin
            cur_ln  = sat_inc(cur_ln);
            cur_col = 16'd1;
        end else begin
            cur_col = sat_inc(cur_col);
        end
    endtask

    // Names match a keyword only when the whole name is the keyword.
    function automatic logic [5:0] name_kind();
        bit same;
        if (run_len > KwChars) return KIND_IDENT;
        foreach (kw_word[k]) begin
            same = (kw_word[k].len() == run_len);
            for (int i = 0; i < kw_word[k].len() && same; i++)
                if (prefix[i] != kw_word[k][i]) same = 0;
            if (same) return kw_kind[k];
        end
        return KIND_IDENT;
    endfunction

    // Emits a name, integer or waiting operator that the next byte closes.
    task automatic close_token();
        int unsigned ec;
        logic [5:0]  kind;
        ec = (run_len == 0) ? tok_col : tok_col + run_len - 1;
        if (ec > PosMax) ec = PosMax;
        if (mode == MODE_NUMBER || mode == MODE_NAME) begin
            kind = (mode == MODE_NUMBER) ? KIND_INTEGER : name_kind();
            add_token(kind, tok_ln, tok_col, tok_ln, ec[15:0], run_len, 8'd0);
        end else if (mode == MODE_OPERATOR) begin
            case (pend)
                ":": add_token(KIND_COLON, tok_ln, tok_col, tok_ln, tok_col, 16'd1, 8'd0);
                "=": add_token(KIND_EQUAL, tok_ln, tok_col, tok_ln, tok_col, 16'd1, 8'd0);
                "<": add_token(KIND_LESS, tok_ln, tok_col, tok_ln, tok_col, 16'd1, 8'd0);
                ">": add_token(KIND_GREATER, tok_ln, tok_col, tok_ln, tok_col, 16'd1, 8'd0);
                default: add_token(KIND_ERROR, tok_ln, tok_col, tok_ln, tok_col, 16'd1, pend);
            endcase
            pend = 8'd0;
        end
        mode = MODE_IDLE;
    endtask

    task automatic open_token();
        tok_ln  = cur_ln;
        tok_col = cur_col;
        run_len = 16'd1;
    endtask

    task automatic start_from_idle(input logic [7:0] b);
        int k;
        k = single_op(b);
        if (b == " " || b == "\t" || b == "\n") begin
        end else if (b == "#") begin
            mode = MODE_COMMENT;
        end else if (is_dig(b)) begin
            open_token();
            mode = MODE_NUMBER;
        end else if (is_let(b)) begin
            open_token();
            foreach (prefix[i]) prefix[i] = 8'd0;
            prefix[0] = b;
            mode = MODE_NAME;
        end else if (k != NO_KIND) begin
            add_token(k[5:0], cur_ln, cur_col, cur_ln, cur_col, 16'd1, 8'd0);
        end else if (b == ":" || b == "=" || b == "<" || b == ">" || b == "!") begin
            open_token();
            pend = b;
            mode = MODE_OPERATOR;
        end else begin
            add_token(KIND_ERROR, cur_ln, cur_col, cur_ln, cur_col, 16'd1, b);
        end
        advance(b);
    endtask

    // Works out the tokens that one accepted request gives.
    task automatic predict_tokens(input logic [7:0] b, input logic eot);
        bit done;
        int k;
        done = 0;
        step_out.delete();
        if (eot) begin
            close_token();
            add_token(KIND_EOF, cur_ln, cur_col, cur_ln, cur_col, 16'd5, 8'd0);
            clear_state();
        end else begin
            case (mode)
                MODE_NUMBER: if (is_dig(b)) begin
                    run_len = sat_inc(run_len);
                    advance(b);
                    done = 1;
                end
                MODE_NAME: if (is_let(b) || is_dig(b)) begin
                    if (run_len < KwChars) prefix[run_len] = b;
                    run_len = sat_inc(run_len);
                    advance(b);
                    done = 1;
                end
                MODE_COMMENT: if (b != "\n") begin
                    advance(b);
                    done = 1;
                end else begin
                    mode = MODE_IDLE;
                end
                MODE_OPERATOR: begin
                    k = double_op(pend, b);
                    if (k != NO_KIND) begin
                        add_token(k[5:0], tok_ln, tok_col, cur_ln, cur_col, 16'd2, 8'd0);
                        pend = 8'd0;
                        mode = MODE_IDLE;
                        advance(b);
                        done = 1;
                    end
                end
                default: mode = MODE_IDLE;
            endcase
            if (!done) begin
                close_token();
                start_from_idle(b);
            end
        end
        if (step_out.size() > 0) step_out[$].last = 1'b1;
        foreach (step_out[i]) tokens_due.push_back(step_out[i]);
    endtask

    // Requests are predicted before results are compared in the same edge.
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            clear_state();
            tokens_due.delete();
        end else begin
            if (i_valid && !i_in_stall) predict_tokens(i_text_byte, i_end_of_text);
            if (i_out_valid && !i_out_stall) begin
                got = '{i_token_kind, i_start_line, i_start_column, i_end_line,
                        i_end_column, i_token_length, i_bad_byte, i_last_of_run};
                if (tokens_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("unexpected token kind %0d at %0d:%0d",
                                 got.kind, got.sl, got.sc);
                end else begin
                    want = tokens_due.pop_front();
                    if (got.kind !== want.kind || got.sl !== want.sl || got.sc !== want.sc ||
                        got.el !== want.el || got.ec !== want.ec || got.len !== want.len ||
                        got.bad !== want.bad || got.last !== want.last) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display({"token mismatch: expected k%0d %0d:%0d-%0d:%0d",
                                      " len %0d bad %0d last %0d, got k%0d",
                                      " %0d:%0d-%0d:%0d len %0d bad %0d last %0d"},
                                     want.kind, want.sl, want.sc, want.el, want.ec,
                                     want.len, want.bad, want.last, got.kind, got.sl,
                                     got.sc, got.el, got.ec, got.len, got.bad, got.last);
                    end
                end
            end
        end
    end

endmodule

FILE: sim/testbench.sv
// Top of the source token scanner testbench: clock, reset, source text and
// result back-pressure, watchdog and verdict.
// Depends on source_token_scanner and token_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TOTAL_BYTES = 500;
    localparam int HOLD_START = 200;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_text_byte = 8'd0;
    logic        i_end_of_text = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [5:0]  o_token_kind;
    logic [15:0] o_start_line, o_start_column, o_end_line, o_end_column, o_token_length;
    logic [7:0]  o_bad_byte;
    logic        o_last_of_run;
    int          failures, tokens_waiting;
    int          burst_left = 0;
    int          sent = 0;
    int          quiet = 0;

    string kw_text [15] = '{"and", "bool", "break", "continue", "do", "else", "if", "int",
                            "not", "or", "return", "then", "while", "true", "false"};
    string op_text [22] = '{"+", "-", "*", "/", "(", ")", "[", "]", "{", "}", ",", ";",
                            ":", ":=", "=", "==", "=>", "<", "<=", ">", ">=", "!="};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    source_token_scanner uut (.*);

    token_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_text_byte, .i_end_of_text,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_token_kind(o_token_kind),
        .i_start_line(o_start_line), .i_start_column(o_start_column),
        .i_end_line(o_end_line), .i_end_column(o_end_column),
        .i_token_length(o_token_length), .i_bad_byte(o_bad_byte),
        .i_last_of_run(o_last_of_run), .o_errors(failures), .o_pending(tokens_waiting)
    );

    // Result back-pressure: a randomly chosen stall pattern, plus one
    // long hold-off while the source keeps offering bytes.
    always @(negedge i_clk) begin
        int cyc;
        int style;
        if (cyc % 64 == 0) style = $urandom_range(0, 2);
        cyc++;
        if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
            i_stall <= 1'b1;
        else if (style == 0)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 9) < (style == 1 ? 3 : 7));
    end

    // Watchdog on cycles in which neither channel moves.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offers one request, in bursts with random gaps, and waits for acceptance.
    task automatic offer(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic offer_text(input string s);
        foreach (s[i]) offer(s[i], 1'b0);
    endtask

    task automatic end_text();
        offer(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // One piece of well-formed text with random content, or noise.
    task automatic random_piece();
        int n;
        case ($urandom_range(0, 9))
            0: offer_text(kw_text[$urandom_range(0, 14)]);
            1: begin
                n = $urandom_range(1, 12);
                offer(8'($urandom_range(0, 1) ? "_" : "a" + $urandom_range(0, 25)), 1'b0);
                repeat (n - 1) offer(8'("0" + $urandom_range(0, 9) +
                                        ($urandom_range(0, 1) ? 0 : "a" - "0")), 1'b0);
            end
            2: repeat ($urandom_range(1, 6)) offer(8'("0" + $urandom_range(0, 9)), 1'b0);
            3, 4: offer_text(op_text[$urandom_range(0, 21)]);
            5: begin
                offer("#", 1'b0);
                repeat ($urandom_range(0, 6)) offer(8'($urandom_range(0, 255)), 1'b0);
                offer("\n", 1'b0);
            end
            6: offer(8'($urandom_range(0, 255)), 1'b0);
            7: offer("!", 1'b0);
            8: if ($urandom_range(0, 15) == 0) end_text();
            default: case ($urandom_range(0, 2))
                0: offer(" ", 1'b0);
                1: offer("\t", 1'b0);
                default: offer("\n", 1'b0);
            endcase
        endcase
        if ($urandom_range(0, 2) == 0) offer(" ", 1'b0);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: keywords whole and partial, every operator but = and =>, lone bang,
        // invalid bytes, comments and end of text in the middle of tokens.
        offer_text("if x1:=42#c\nwhile<=>=!=!a==>=<>:;,+-*/()[]{} continuex true false ");
        offer_text("and bool break do else int not or return then _Z9 continue ");
        offer(8'h00, 1'b0);
        offer(8'h0D, 1'b0);
        offer(8'hFF, 1'b0);
        offer_text("! !=");
        offer_text("abc");
        end_text();
        offer_text(">");
        end_text();
        offer_text("#x");
        end_text();

        // Random text up to the total byte count.
        while (sent < TOTAL_BYTES)
            random_piece();
        end_text();
        i_valid <= 1'b0;

        while (tokens_waiting != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
design/sts_pkg.sv
design/sts_front.sv
design/sts_back.sv
design/source_token_scanner.sv
sim/token_checker.sv
sim/testbench.sv
